### hw/rtl/prfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_pkg
// Types and constant tables shared by the pts reorder frame rate detector.
// ----------------------------------------------------------------------------
package prfr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_CHECK,
    ST_HEAD,
    ST_RATE,
    ST_OUT
  } st_e;

  typedef enum logic [2:0] {
    RATE_NONE,
    RATE_5994,
    RATE_50,
    RATE_4995,
    RATE_2997,
    RATE_25,
    RATE_24975,
    RATE_23976
  } rate_e;

  localparam int DurBits   = 32;
  localparam int CountBits = 5;
  localparam int TickBits  = 12;
  localparam int BandBits  = 16;

  // integer part of each frame rate
  function automatic logic [5:0] rate_int(rate_e r);
    logic [5:0] v;
    unique case (r)
      RATE_NONE:  v = 6'd0;
      RATE_5994:  v = 6'd59;
      RATE_50:    v = 6'd50;
      RATE_4995:  v = 6'd49;
      RATE_2997:  v = 6'd29;
      RATE_25:    v = 6'd25;
      RATE_24975: v = 6'd24;
      RATE_23976: v = 6'd23;
      default:    v = 6'd0;
    endcase
    return v;
  endfunction

  // 96 kHz ticks per frame, rounded to nearest
  function automatic logic [TickBits-1:0] rate_ticks(rate_e r);
    logic [TickBits-1:0] v;
    unique case (r)
      RATE_NONE:  v = 12'd0;
      RATE_5994:  v = 12'd1602;
      RATE_50:    v = 12'd1920;
      RATE_4995:  v = 12'd1922;
      RATE_2997:  v = 12'd3203;
      RATE_25:    v = 12'd3840;
      RATE_24975: v = 12'd3844;
      RATE_23976: v = 12'd4004;
      default:    v = 12'd0;
    endcase
    return v;
  endfunction

  // frame duration in microseconds to rate, all bands lie inside 15000..50000
  function automatic rate_e match_band(logic [BandBits-1:0] d);
    rate_e r;
    priority if (d >= 16'd16000 && d <= 16'd17000) r = RATE_5994;
    else if (d == 16'd20000) r = RATE_50;
    else if (d == 16'd20020) r = RATE_4995;
    else if (d >= 16'd32000 && d <= 16'd35000) r = RATE_2997;
    else if (d == 16'd40000) r = RATE_25;
    else if (d == 16'd40040) r = RATE_24975;
    else if (d >= 16'd40200 && d <= 16'd43200) r = RATE_23976;
    else r = RATE_NONE;
    return r;
  endfunction

endpackage

### hw/rtl/prfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pts_reorder_frame_rate_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_reorder_frame_rate_detect
// Sorted timestamp queue that undoes packet reordering and detects frame rate.
// ----------------------------------------------------------------------------
// Each push beat adds one timestamp (pts, else dts, else an invalid entry with
// key zero) into a queue held in a small RAM as a ring, sorted ascending;
// equal keys go after existing ones. Once the queue holds more than
// MEASURE_THRESHOLD entries the head is popped and its distance to the
// previous head is matched against the frame rate bands. The insertion scan
// moves each entry that sorts above the new one (at most MEASURE_THRESHOLD)
// up one slot, reading one queue entry per cycle from the single RAM read
// port. A flush beat empties the queue. The result register lets the next
// beat be accepted while a result still waits on the output.
module pts_reorder_frame_rate_detect #(
  parameter int MEASURE_THRESHOLD = 16,
  parameter int TIME_BITS         = 48
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    func_i,
  input  logic signed [TIME_BITS-1:0]             pts_time_i,
  input  logic                                    pts_valid_i,
  input  logic signed [TIME_BITS-1:0]             dts_time_i,
  input  logic                                    dts_valid_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    measured_o,
  output logic signed [prfr_pkg::DurBits-1:0]     duration_o,
  output logic                                    rate_changed_o,
  output logic [2:0]                              rate_code_o,
  output logic [prfr_pkg::TickBits-1:0]           ticks_per_frame_o,
  output logic [prfr_pkg::CountBits-1:0]          queue_count_o
);
  import prfr_pkg::*;

  localparam int Slots = MEASURE_THRESHOLD + 1;
  localparam int PW    = $clog2(Slots);
  localparam int CW    = $clog2(Slots + 1);
  localparam int SW    = CW + 1;
  localparam int EW    = TIME_BITS + 1;
  localparam int DW    = TIME_BITS + 1;
  localparam logic signed [DW-1:0] SatHi = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] SatLo = DW'(-64'sd2147483648);

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(Slots - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(logic [PW-1:0] p);
    return (p == '0) ? PW'(Slots - 1) : p - PW'(1);
  endfunction

  st_e                         state_q, state_d;
  logic [PW-1:0]               base_q, ptr_q, idx_q;
  logic [CW-1:0]               count_q;
  logic signed [TIME_BITS-1:0] key_q;
  logic                        key_vld_q;
  logic [TIME_BITS-1:0]        last_time_q;
  logic                        last_vld_q;
  rate_e                       rate_q;
  logic signed [DW-1:0]        diff_q;
  logic                        diff_ok_q;
  logic                        meas_q, chg_q;
  logic signed [DurBits-1:0]   dur_q;

  logic                        out_valid_q, out_meas_q, out_chg_q;
  logic signed [DurBits-1:0]   out_dur_q;
  rate_e                       out_rate_q;
  logic [CW-1:0]               out_count_q;

  logic                        ram_we, ram_re;
  logic [PW-1:0]               ram_waddr, ram_raddr;
  logic [EW-1:0]               ram_wdata, ram_rdata;

  logic                        accept, out_load, gt, dur_narrow;
  logic [SW-1:0]               tail_sum;
  logic [PW-1:0]               tail_ptr;
  logic signed [TIME_BITS-1:0] rd_time;
  logic                        rd_vld;
  logic signed [TIME_BITS-1:0] in_key;
  rate_e                       band;

  prfr_ram #(
    .Width(EW),
    .Depth(Slots)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_vld   = ram_rdata[TIME_BITS];
  assign rd_time  = $signed(ram_rdata[TIME_BITS-1:0]);
  assign gt       = rd_time > key_q;
  assign accept   = in_valid_i && in_ready_o;
  assign out_load = !out_valid_q || out_ready_i;
  assign in_key   = pts_valid_i ? pts_time_i : (dts_valid_i ? dts_time_i : '0);

  // last occupied slot of the ring
  always_comb begin
    tail_sum = SW'(base_q) + SW'(count_q) - SW'(1);
    if (tail_sum >= SW'(Slots)) begin
      tail_sum = tail_sum - SW'(Slots);
    end
    tail_ptr = tail_sum[PW-1:0];
  end

  assign dur_narrow = (diff_q[DW-1:BandBits] == '0);
  assign band       = dur_narrow ? match_band(diff_q[BandBits-1:0]) : RATE_NONE;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i) begin
            state_d = ST_OUT;
          end else if (count_q >= CW'(Slots)) begin
            state_d = ST_CHECK;
          end else if (count_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!gt) begin
          state_d = ST_CHECK;
        end else if (idx_q == '0) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: state_d = ST_CHECK;
      ST_CHECK: state_d = (count_q > CW'(MEASURE_THRESHOLD)) ? ST_HEAD : ST_OUT;
      ST_HEAD:  state_d = ST_RATE;
      ST_RATE:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake and RAM control
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = {key_vld_q, key_q};
    ram_re     = 1'b0;
    ram_raddr  = tail_ptr;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = 1'b1;
      end
      ST_SCAN: begin
        // shift the larger entry up one slot and prefetch the one below, else place the new key
        ram_we    = 1'b1;
        ram_waddr = ptr_inc(ptr_q);
        ram_wdata = gt ? ram_rdata : {key_vld_q, key_q};
        ram_re    = gt;
        ram_raddr = ptr_dec(ptr_q);
      end
      ST_PLACE: ram_we = 1'b1;
      ST_CHECK: begin
        ram_re    = 1'b1;
        ram_raddr = base_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      count_q     <= '0;
      last_time_q <= '0;
      last_vld_q  <= 1'b1;
      rate_q      <= RATE_NONE;
      out_valid_q <= 1'b0;
      out_rate_q  <= RATE_NONE;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (func_i) begin
              count_q <= '0;
            end else if (count_q < CW'(Slots)) begin
              count_q <= count_q + CW'(1);
            end
          end
        end
        ST_HEAD: begin
          last_time_q <= ram_rdata[TIME_BITS-1:0];
          last_vld_q  <= rd_vld;
          base_q      <= ptr_inc(base_q);
          count_q     <= count_q - CW'(1);
        end
        ST_RATE: begin
          if (diff_ok_q && band != RATE_NONE && rate_int(band) != rate_int(rate_q)) begin
            rate_q <= band;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_rate_q  <= rate_q;
          end
        end
        default: ;
      endcase
      if (out_valid_q && out_ready_i && !(state_q == ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_q     <= in_key;
          key_vld_q <= pts_valid_i || dts_valid_i;
          meas_q    <= 1'b0;
          chg_q     <= 1'b0;
          dur_q     <= '0;
          ptr_q     <= (count_q == '0) ? base_q : tail_ptr;
          idx_q     <= PW'(count_q - CW'(1));
        end
      end
      ST_SCAN: begin
        if (gt && idx_q != '0) begin
          ptr_q <= ptr_dec(ptr_q);
          idx_q <= idx_q - PW'(1);
        end
      end
      ST_HEAD: begin
        meas_q    <= 1'b1;
        diff_ok_q <= rd_vld && last_vld_q;
        diff_q    <= $signed({ram_rdata[TIME_BITS-1], ram_rdata[TIME_BITS-1:0]})
                   - $signed({last_time_q[TIME_BITS-1], last_time_q});
      end
      ST_RATE: begin
        if (diff_ok_q) begin
          if (diff_q > SatHi) begin
            dur_q <= DurBits'(SatHi);
          end else if (diff_q < SatLo) begin
            dur_q <= DurBits'(SatLo);
          end else begin
            dur_q <= diff_q[DurBits-1:0];
          end
          chg_q <= band != RATE_NONE && rate_int(band) != rate_int(rate_q);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_meas_q  <= meas_q;
          out_dur_q   <= dur_q;
          out_chg_q   <= chg_q;
          out_count_q <= count_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign measured_o        = out_meas_q;
  assign duration_o        = out_dur_q;
  assign rate_changed_o    = out_chg_q;
  assign rate_code_o       = out_rate_q;
  assign ticks_per_frame_o = rate_ticks(out_rate_q);
  assign queue_count_o     = CountBits'(out_count_q);

endmodule

### hw/rtl/prfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_checker
// Port level checks on the result channel of the frame rate detector.
// ----------------------------------------------------------------------------
module prfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        measured_o,
  input logic [31:0] duration_o,
  input logic        rate_changed_o,
  input logic [2:0]  rate_code_o,
  input logic [11:0] ticks_per_frame_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duration_o)
      && $stable(rate_code_o) && $stable(measured_o))
    else $error("result beat changed while stalled");

  a_change_measured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rate_changed_o |-> measured_o && rate_code_o != 3'd0)
    else $error("rate change without measurement");

  a_idle_duration: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !measured_o |-> duration_o == 32'd0)
    else $error("duration without measurement");

  a_ticks_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((ticks_per_frame_o == 12'd0) == (rate_code_o == 3'd0)))
    else $error("ticks disagree with rate code");

  // the reported rate only moves together with a change flag
  a_rate_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rate_code_o) |-> out_valid_o && rate_changed_o)
    else $error("rate code moved without change flag");

endmodule

bind pts_reorder_frame_rate_detect prfr_checker u_prfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .measured_o       (measured_o),
  .duration_o       (duration_o),
  .rate_changed_o   (rate_changed_o),
  .rate_code_o      (rate_code_o),
  .ticks_per_frame_o(ticks_per_frame_o)
);

### bench/pts_reorder_frame_rate_detect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_reorder_frame_rate_detect_tb
// Self-checking bench for the pts reorder queue and frame rate detector.
// ----------------------------------------------------------------------------
// Timestamp streams with B-frame style reordering, jitter and invalid
// entries are pushed at a range of frame periods, mixed with flushes and
// random beats. A model of the sorted queue predicts every result beat, and
// the monitor compares each one field by field. Both sides idle at random,
// and the receiver holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module pts_reorder_frame_rate_detect_tb;
  import prfr_pkg::*;

  localparam int TIME_BITS   = 48;
  localparam int QUEUE_DEPTH = 16;
  localparam int ITEM_TARGET = 580;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct {
    logic                        func;
    logic signed [TIME_BITS-1:0] pts;
    logic                        pts_v;
    logic signed [TIME_BITS-1:0] dts;
    logic                        dts_v;
  } ts_beat_t;

  typedef struct {
    logic                      measured;
    logic signed [DurBits-1:0] duration;
    logic                      changed;
    rate_e                     rate;
    logic [TickBits-1:0]       ticks;
    logic [CountBits-1:0]      count;
  } frame_stat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_ready_o;
  logic                        func = FUNC_PUSH;
  logic signed [TIME_BITS-1:0] pts_time = '0;
  logic                        pts_valid = 1'b0;
  logic signed [TIME_BITS-1:0] dts_time = '0;
  logic                        dts_valid = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready = 1'b0;
  logic                        measured_o;
  logic signed [DurBits-1:0]   duration_o;
  logic                        rate_changed_o;
  logic [2:0]                  rate_code_o;
  logic [TickBits-1:0]         ticks_per_frame_o;
  logic [CountBits-1:0]        queue_count_o;

  pts_reorder_frame_rate_detect #(
    .MEASURE_THRESHOLD(QUEUE_DEPTH),
    .TIME_BITS        (TIME_BITS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .func_i           (func),
    .pts_time_i       (pts_time),
    .pts_valid_i      (pts_valid),
    .dts_time_i       (dts_time),
    .dts_valid_i      (dts_valid),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .measured_o       (measured_o),
    .duration_o       (duration_o),
    .rate_changed_o   (rate_changed_o),
    .rate_code_o      (rate_code_o),
    .ticks_per_frame_o(ticks_per_frame_o),
    .queue_count_o    (queue_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  longint slot_time [0:QUEUE_DEPTH];
  bit     slot_ok   [0:QUEUE_DEPTH];
  int     n_slots = 0;
  longint prev_head_time = 0;
  bit     prev_head_ok = 1'b1;
  rate_e  cur_rate = RATE_NONE;

  int          whole_fps [8] = '{0, 59, 50, 49, 29, 25, 24, 23};
  int unsigned tick_tab  [8] = '{0, 1602, 1920, 1922, 3203, 3840, 3844, 4004};

  function automatic rate_e band_of(longint d);
    if (d < 15000 || d > 50000) return RATE_NONE;
    if (d >= 16000 && d <= 17000) return RATE_5994;
    if (d == 20000) return RATE_50;
    if (d == 20020) return RATE_4995;
    if (d >= 32000 && d <= 35000) return RATE_2997;
    if (d == 40000) return RATE_25;
    if (d == 40040) return RATE_24975;
    if (d >= 40200 && d <= 43200) return RATE_23976;
    return RATE_NONE;
  endfunction

  function automatic frame_stat_t predict_frame_stat(ts_beat_t b);
    frame_stat_t r;
    longint      t;
    longint      d;
    bit          ok;
    int          pos;
    int          i;
    rate_e       hit;
    r.measured = 1'b0;
    r.duration = '0;
    r.changed  = 1'b0;
    if (b.func == FUNC_FLUSH) begin
      n_slots = 0;
    end else begin
      ok = b.pts_v || b.dts_v;
      t = 0;
      if (b.pts_v) t = b.pts;
      else if (b.dts_v) t = b.dts;
      // equal keys land behind the ones already queued
      pos = 0;
      while (pos < n_slots && slot_time[pos] <= t) pos++;
      for (i = n_slots; i > pos; i--) begin
        slot_time[i] = slot_time[i-1];
        slot_ok[i]   = slot_ok[i-1];
      end
      slot_time[pos] = t;
      slot_ok[pos]   = ok;
      n_slots++;
      if (n_slots > QUEUE_DEPTH) begin
        r.measured = 1'b1;
        if (slot_ok[0] && prev_head_ok) begin
          d = slot_time[0] - prev_head_time;
          hit = band_of(d);
          if (d > 64'sd2147483647) r.duration = 32'sh7fff_ffff;
          else if (d < -64'sd2147483648) r.duration = 32'sh8000_0000;
          else r.duration = d[DurBits-1:0];
          if (hit != RATE_NONE && whole_fps[int'(hit)] != whole_fps[int'(cur_rate)]) begin
            cur_rate  = hit;
            r.changed = 1'b1;
          end
        end
        prev_head_time = slot_time[0];
        prev_head_ok   = slot_ok[0];
        for (i = 1; i < n_slots; i++) begin
          slot_time[i-1] = slot_time[i];
          slot_ok[i-1]   = slot_ok[i];
        end
        n_slots--;
      end
    end
    r.rate  = cur_rate;
    r.ticks = TickBits'(tick_tab[int'(cur_rate)]);
    r.count = CountBits'(n_slots);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  ts_beat_t    push_backlog [$];
  frame_stat_t frame_stat_due [$];
  int          beats_sent = 0;
  int          stats_seen = 0;
  int          mismatch_cnt = 0;

  int period_menu [31] = '{15000, 14999, 15999, 16000, 16683, 17000, 17001, 19999,
                           20000, 20001, 20019, 20020, 20021, 31999, 32000, 33367,
                           35000, 35001, 39999, 40000, 40001, 40039, 40040, 40041,
                           40199, 40200, 41708, 43200, 43201, 50000, 50001};

  function automatic logic [TIME_BITS-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_BITS-1:0];
  endfunction

  // some stretches run without idling at all
  function automatic int draw_wait(int n);
    if ((n / 40) % 4 == 1) return 0;
    return $urandom_range(0, 7);
  endfunction

  task automatic add_beat(logic f, logic [TIME_BITS-1:0] p, logic pv,
                          logic [TIME_BITS-1:0] d, logic dv);
    ts_beat_t b;
    b.func  = f;
    b.pts   = p;
    b.pts_v = pv;
    b.dts   = d;
    b.dts_v = dv;
    push_backlog.push_back(b);
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      add_beat(($urandom_range(0, 7) == 0) ? FUNC_FLUSH : FUNC_PUSH, rand48(),
               1'($urandom_range(0, 1)), rand48(), 1'($urandom_range(0, 1)));
    end
  endtask

  // one stream of frames at a fixed period, second and third of each three swapped if reordered
  task automatic add_stream();
    longint base;
    longint per;
    longint ts;
    int     len;
    int     jit_max;
    int     j;
    int     idx;
    int     kind;
    bit     reorder;
    logic [TIME_BITS-1:0] stamp;
    case ($urandom_range(0, 3))
      0: base = $signed(rand48());
      1: base = $urandom_range(0, 1000000);
      2: base = 64'sh7fff_ffff_ffff - $urandom_range(0, 2000000);
      default: base = -longint'($urandom_range(0, 2000000000));
    endcase
    if ($urandom_range(0, 9) < 7) per = period_menu[$urandom_range(0, $size(period_menu) - 1)];
    else if ($urandom_range(0, 4) != 0) per = $urandom_range(14000, 52000);
    else per = $urandom_range(0, 32'h7fff_ffff);
    jit_max = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    reorder = $urandom_range(0, 3) != 0;
    len = 3 * $urandom_range(6, 16);
    if ($urandom_range(0, 3) != 0) add_beat(FUNC_FLUSH, rand48(), 1'($urandom_range(0, 1)),
                                            rand48(), 1'($urandom_range(0, 1)));
    for (j = 0; j < len; j++) begin
      idx = j;
      if (reorder && j % 3 == 1) idx = j + 1;
      if (reorder && j % 3 == 2) idx = j - 1;
      ts = base + idx * per + $urandom_range(0, jit_max);
      stamp = ts[TIME_BITS-1:0];
      kind = $urandom_range(0, 19);
      if (kind == 0) add_beat(FUNC_PUSH, rand48(), 1'b0, rand48(), 1'b0);
      else if (kind < 4) add_beat(FUNC_PUSH, rand48(), 1'b0, stamp, 1'b1);
      else add_beat(FUNC_PUSH, stamp, 1'b1, rand48(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : main_seq
    int i;
    // directed: extremes, invalid keys, equal keys, saturation, flush
    add_beat(FUNC_FLUSH, 48'h7fff_ffff_ffff, 1'b1, 48'h8000_0000_0000, 1'b1);
    add_beat(FUNC_PUSH, 48'h7fff_ffff_ffff, 1'b1, 48'h0000_0000_0000, 1'b1);
    add_beat(FUNC_PUSH, 48'h8000_0000_0000, 1'b1, 48'hffff_ffff_ffff, 1'b1);
    add_beat(FUNC_PUSH, 48'hffff_ffff_ffff, 1'b0, 48'h7fff_ffff_ffff, 1'b1);
    add_beat(FUNC_PUSH, 48'h0000_0000_0000, 1'b0, 48'h8000_0000_0000, 1'b1);
    add_beat(FUNC_PUSH, 48'hffff_ffff_ffff, 1'b0, 48'hffff_ffff_ffff, 1'b0);
    add_beat(FUNC_PUSH, 48'h0000_0000_0000, 1'b0, 48'h0000_0000_0000, 1'b0);
    add_beat(FUNC_PUSH, 48'h0000_0000_0000, 1'b1, 48'h5555_5555_5555, 1'b1);
    add_beat(FUNC_PUSH, 48'haaaa_aaaa_aaaa, 1'b0, 48'h0000_0000_0000, 1'b1);
    for (i = 1; i <= 15; i++) begin
      add_beat(FUNC_PUSH, 48'(16683 * i), 1'b1, 48'h0, 1'b0);
    end
    add_beat(FUNC_FLUSH, 48'h0, 1'b0, 48'h0, 1'b0);

    while (push_backlog.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_stream();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (push_backlog.size() > 0 || in_valid || frame_stat_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("pts_reorder_frame_rate_detect regression: pass");
    end else begin
      $display("pts_reorder_frame_rate_detect regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  ts_beat_t cur_beat;
  int       gap_left = 0;

  always @(posedge clk_i) begin : drive_proc
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready_o) begin
        frame_stat_due.push_back(predict_frame_stat(cur_beat));
        beats_sent++;
        nxt_valid = 1'b0;
        gap_left = draw_wait(beats_sent);
      end else if (!in_valid && gap_left > 0) begin
        gap_left--;
      end
      if (!nxt_valid && gap_left == 0 && push_backlog.size() > 0) begin
        cur_beat = push_backlog.pop_front();
        func      <= cur_beat.func;
        pts_time  <= cur_beat.pts;
        pts_valid <= cur_beat.pts_v;
        dts_time  <= cur_beat.dts;
        dts_valid <= cur_beat.dts_v;
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------- monitor

  int stall_left = 0;
  int hold_left = 0;

  task automatic flag(string name, longint want, longint got);
    $error("%s mismatch: expected %0d, got %0d", name, want, got);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : watch_proc
    frame_stat_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        stats_seen++;
        if (frame_stat_due.size() == 0) begin
          $error("result beat with no expectation pending");
          mismatch_cnt++;
        end else begin
          want = frame_stat_due.pop_front();
          if (measured_o !== want.measured) flag("measured", want.measured, measured_o);
          if (duration_o !== want.duration) flag("duration", want.duration, duration_o);
          if (rate_changed_o !== want.changed) flag("rate_changed", want.changed, rate_changed_o);
          if (rate_code_o !== want.rate) flag("rate_code", int'(want.rate), rate_code_o);
          if (ticks_per_frame_o !== want.ticks)
            flag("ticks_per_frame", want.ticks, ticks_per_frame_o);
          if (queue_count_o !== want.count) flag("queue_count", want.count, queue_count_o);
        end
        stall_left = draw_wait(stats_seen + 80);
        // one long hold-off so the block backs up and stalls its input
        if (stats_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end else begin
        if (stall_left > 0) stall_left--;
        if (hold_left > 0) hold_left--;
      end
      out_ready <= (stall_left == 0 && hold_left == 0);
    end
  end

  // ---------------------------------------------------------------- watchdog

  int cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pts_reorder_frame_rate_detect regression: fail");
      $finish;
    end
  end

endmodule

### sim.f
hw/rtl/prfr_pkg.sv
hw/rtl/prfr_ram.sv
hw/rtl/pts_reorder_frame_rate_detect.sv
hw/rtl/prfr_checker.sv
bench/pts_reorder_frame_rate_detect_tb.sv
